// ===== design/tdc_enc_pkg.sv =====
// Shared types and constants for the TDC edge-time encoder.
package tdc_enc_pkg;

  localparam int unsigned NBINS      = 50;
  localparam int unsigned MAX_COARSE = 16;

  localparam int unsigned AMP_W    = 16;
  localparam int unsigned CODE_W   = 7;
  localparam int unsigned FINE_W   = 6;
  localparam int unsigned PHASE_W  = 2;
  localparam int unsigned COARSE_W = 4;
  localparam int unsigned PACK_W   = 14;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [FINE_W-1:0]   NBINS_F      = FINE_W'(NBINS);
  localparam logic [COARSE_W-1:0] COARSE_LAST  = COARSE_W'(MAX_COARSE - 1);
  localparam logic [PACK_W-1:0]   FALL_WEIGHT  = PACK_W'(2 * NBINS);
  localparam logic [PHASE_W-1:0]  PHASE_LAST   = PHASE_W'(2);

  localparam logic [CODE_W-1:0] NO_TRANS_RST  = CODE_W'(63);
  localparam logic [CODE_W-1:0] ALREADY_RST   = CODE_W'(62);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_NO_TRANS  = 2'd1,
    CFG_ALREADY   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic signed [AMP_W-1:0] amplitude;
    logic                    frame_start;
  } tdc_in_t;

  typedef struct packed {
    logic [PACK_W-1:0]   packed_tdc;
    logic [CODE_W-1:0]   rising_edge;
    logic [CODE_W-1:0]   falling_edge;
    logic [COARSE_W-1:0] coarse_index;
  } tdc_out_t;

  typedef struct packed {
    logic signed [AMP_W-1:0] threshold;
    logic [CODE_W-1:0]       no_trans_code;
    logic [CODE_W-1:0]       already_code;
  } tdc_cfg_t;

  typedef struct packed {
    logic                above;
    logic [CODE_W-1:0]   rise;
    logic [CODE_W-1:0]   fall;
    logic [FINE_W-1:0]   fine;
    logic [PHASE_W-1:0]  phase;
    logic [COARSE_W-1:0] coarse;
  } tdc_state_t;

endpackage

// ===== design/tdc_enc_step.sv =====
// Per-sample update: threshold compare, edge capture, counters and result packing.
module tdc_enc_step (
  input  tdc_enc_pkg::tdc_state_t cur_i,
  input  tdc_enc_pkg::tdc_cfg_t   cfg_i,
  input  tdc_enc_pkg::tdc_in_t    word_i,
  output tdc_enc_pkg::tdc_state_t nxt_o,
  output logic                    emit_o,
  output tdc_enc_pkg::tdc_out_t   res_o
);

  tdc_enc_pkg::tdc_state_t s0;
  logic [tdc_enc_pkg::FINE_W-1:0]   fine_inc;
  logic [tdc_enc_pkg::PACK_W-1:0]   fall_scaled;
  logic                             above_n;
  logic [tdc_enc_pkg::CODE_W-1:0]   rise_n;
  logic [tdc_enc_pkg::CODE_W-1:0]   fall_n;

  // frame start clears flag and counters first
  always_comb begin
    s0 = cur_i;
    if (word_i.frame_start) begin
      s0.above  = 1'b0;
      s0.fine   = '0;
      s0.phase  = '0;
      s0.coarse = '0;
    end
  end

  always_comb begin
    above_n = s0.above;
    rise_n  = s0.rise;
    fall_n  = s0.fall;
    if (s0.fine == '0) begin
      if (s0.above) begin
        rise_n = cfg_i.already_code;
        fall_n = cfg_i.no_trans_code;
      end else begin
        rise_n = cfg_i.no_trans_code;
        fall_n = cfg_i.already_code;
      end
    end
    if (s0.above) begin
      if ((s0.phase == '0) && (word_i.amplitude < cfg_i.threshold)) begin
        above_n = 1'b0;
        fall_n  = tdc_enc_pkg::CODE_W'(s0.fine);
      end
    end else if (word_i.amplitude > cfg_i.threshold) begin
      above_n = 1'b1;
      rise_n  = tdc_enc_pkg::CODE_W'(s0.fine);
      fall_n  = cfg_i.no_trans_code;
    end
  end

  assign fine_inc = s0.fine + 1'b1;
  assign emit_o   = (fine_inc == tdc_enc_pkg::NBINS_F);

  always_comb begin
    nxt_o.above  = above_n;
    nxt_o.rise   = rise_n;
    nxt_o.fall   = fall_n;
    nxt_o.fine   = emit_o ? '0 : fine_inc;
    nxt_o.phase  = (s0.phase >= tdc_enc_pkg::PHASE_LAST) ? '0 : s0.phase + 1'b1;
    nxt_o.coarse = s0.coarse;
    if (emit_o) begin
      nxt_o.coarse = (s0.coarse == tdc_enc_pkg::COARSE_LAST) ? '0 : s0.coarse + 1'b1;
    end
  end

  assign fall_scaled = tdc_enc_pkg::FALL_WEIGHT
                     * {{(tdc_enc_pkg::PACK_W - tdc_enc_pkg::CODE_W){1'b0}}, fall_n};

  assign res_o.packed_tdc   = {{(tdc_enc_pkg::PACK_W - tdc_enc_pkg::CODE_W){1'b0}}, rise_n}
                            + fall_scaled;
  assign res_o.rising_edge  = rise_n;
  assign res_o.falling_edge = fall_n;
  assign res_o.coarse_index = s0.coarse;

endmodule

// ===== design/tdc_edge_time_encoder.sv =====
// Top level of the threshold-crossing TDC edge-time encoder.
//
// Usage:
//   in channel  : one fine-time sample per word (amplitude, frame_start).
//   out channel : one word per coarse sample, after every NBINS fine samples,
//                 carrying rising/falling edge codes, their packed form and
//                 the coarse index within the frame.
//   cfg channel : threshold and the two special codes, always ready; write
//                 only while the block is idle.
// Timing: one sample per cycle while no closing sample is held off. A sample
//   that closes a coarse sample loads the output register as it is accepted.
// Throughput: one input word per cycle unless stalled (combinational step).
// Stall: samples that close no coarse sample are taken even while a result
//   waits. A closing sample is held off only while the output register is
//   full and the receiver is not taking it.
// Reset: flag, counters and output valid clear; threshold 0, no-transition
//   code 63, already-transition code 62.
module tdc_edge_time_encoder (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  tdc_enc_pkg::tdc_in_t                   in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output tdc_enc_pkg::tdc_out_t                  out_data_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [tdc_enc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [tdc_enc_pkg::AMP_W-1:0]          cfg_data_i
);

  tdc_enc_pkg::tdc_cfg_t   cfg_q;
  tdc_enc_pkg::tdc_state_t st_q, st_d;
  tdc_enc_pkg::tdc_out_t   res_d, res_q;
  logic                    out_valid_q;
  logic                    emit;
  logic                    in_fire;

  tdc_enc_step u_step (
    .cur_i  (st_q),
    .cfg_i  (cfg_q),
    .word_i (in_data_i),
    .nxt_o  (st_d),
    .emit_o (emit),
    .res_o  (res_d)
  );

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !emit || !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold     <= '0;
      cfg_q.no_trans_code <= tdc_enc_pkg::NO_TRANS_RST;
      cfg_q.already_code  <= tdc_enc_pkg::ALREADY_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tdc_enc_pkg::CFG_THRESHOLD: cfg_q.threshold     <= cfg_data_i;
        tdc_enc_pkg::CFG_NO_TRANS:  cfg_q.no_trans_code <= cfg_data_i[tdc_enc_pkg::CODE_W-1:0];
        tdc_enc_pkg::CFG_ALREADY:   cfg_q.already_code  <= cfg_data_i[tdc_enc_pkg::CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.above  <= 1'b0;
      st_q.rise   <= tdc_enc_pkg::NO_TRANS_RST;
      st_q.fall   <= tdc_enc_pkg::ALREADY_RST;
      st_q.fine   <= '0;
      st_q.phase  <= '0;
      st_q.coarse <= '0;
    end else if (in_fire) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit) begin
      res_q <= res_d;
    end
  end

  a_fine_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.fine < tdc_enc_pkg::NBINS_F)
    else $error("fine position out of range");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.phase <= tdc_enc_pkg::PHASE_LAST)
    else $error("mod-3 phase out of range");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && emit) |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_fire && emit))
    else $error("result raised without a closing sample");

  a_fine_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && emit) |=> (st_q.fine == '0))
    else $error("fine position not cleared after result");

endmodule

// ===== tb/tdc_edge_tb_pkg.sv =====
`timescale 1ns / 100ps
// Edge-code predictor and result scoreboard for the TDC edge-time encoder testbench.
package tdc_edge_tb_pkg;

  class tdc_code_checker;
    tdc_enc_pkg::tdc_cfg_t    regs;
    tdc_enc_pkg::tdc_state_t  track;
    tdc_enc_pkg::tdc_out_t    awaited_codes[$];
    int unsigned n_samples;
    int unsigned n_predicted;
    int unsigned n_checked;
    int unsigned n_errors;

    function new();
      regs.threshold     = '0;
      regs.no_trans_code = tdc_enc_pkg::NO_TRANS_RST;
      regs.already_code  = tdc_enc_pkg::ALREADY_RST;
      track.above  = 1'b0;
      track.rise   = tdc_enc_pkg::NO_TRANS_RST;
      track.fall   = tdc_enc_pkg::ALREADY_RST;
      track.fine   = '0;
      track.phase  = '0;
      track.coarse = '0;
      n_samples    = 0;
      n_predicted  = 0;
      n_checked    = 0;
      n_errors     = 0;
    endfunction

    function void apply_register(logic [tdc_enc_pkg::CFG_IDX_W-1:0] idx,
                                 logic [tdc_enc_pkg::AMP_W-1:0] data);
      case (tdc_enc_pkg::cfg_idx_e'(idx))
        tdc_enc_pkg::CFG_THRESHOLD: regs.threshold     = data;
        tdc_enc_pkg::CFG_NO_TRANS:  regs.no_trans_code = data[tdc_enc_pkg::CODE_W-1:0];
        tdc_enc_pkg::CFG_ALREADY:   regs.already_code  = data[tdc_enc_pkg::CODE_W-1:0];
        default: ;
      endcase
    endfunction

    // Returns 1 when the sample closes a coarse sample.
    function bit advance_fine_sample(tdc_enc_pkg::tdc_in_t s,
                                     output tdc_enc_pkg::tdc_out_t r);
      logic signed [tdc_enc_pkg::AMP_W-1:0] amp;
      logic signed [tdc_enc_pkg::AMP_W-1:0] thr;
      amp = s.amplitude;
      thr = regs.threshold;
      r   = '0;
      if (s.frame_start) begin
        track.above  = 1'b0;
        track.fine   = '0;
        track.phase  = '0;
        track.coarse = '0;
      end
      if (track.fine == '0) begin
        if (track.above) begin
          track.rise = regs.already_code;
          track.fall = regs.no_trans_code;
        end else begin
          track.rise = regs.no_trans_code;
          track.fall = regs.already_code;
        end
      end
      if (track.above) begin
        if (track.phase == '0 && amp < thr) begin
          track.above = 1'b0;
          track.fall  = tdc_enc_pkg::CODE_W'(track.fine);
        end
      end else if (amp > thr) begin
        track.above = 1'b1;
        track.rise  = tdc_enc_pkg::CODE_W'(track.fine);
        track.fall  = regs.no_trans_code;
      end
      track.fine  = track.fine + 1'b1;
      track.phase = (track.phase == tdc_enc_pkg::PHASE_LAST) ? '0 : track.phase + 1'b1;
      if (track.fine < tdc_enc_pkg::NBINS_F) return 1'b0;
      track.fine     = '0;
      r.rising_edge  = track.rise;
      r.falling_edge = track.fall;
      r.packed_tdc   = tdc_enc_pkg::PACK_W'(track.rise)
                     + tdc_enc_pkg::FALL_WEIGHT * tdc_enc_pkg::PACK_W'(track.fall);
      r.coarse_index = track.coarse;
      track.coarse   = (track.coarse == tdc_enc_pkg::COARSE_LAST) ? '0
                                                                  : track.coarse + 1'b1;
      return 1'b1;
    endfunction

    function void note_sample(tdc_enc_pkg::tdc_in_t s);
      tdc_enc_pkg::tdc_out_t r;
      n_samples++;
      if (advance_fine_sample(s, r)) begin
        awaited_codes.push_back(r);
        n_predicted++;
      end
    endfunction

    task report(string what);
      n_errors++;
      $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task check_result(tdc_enc_pkg::tdc_out_t got);
      tdc_enc_pkg::tdc_out_t want;
      if (awaited_codes.size() == 0) begin
        report($sformatf("unexpected word %h", got));
        return;
      end
      want = awaited_codes.pop_front();
      n_checked++;
      if (got.packed_tdc !== want.packed_tdc)
        report($sformatf("coarse %0d packed_tdc got %0d want %0d",
                         want.coarse_index, got.packed_tdc, want.packed_tdc));
      if (got.rising_edge !== want.rising_edge)
        report($sformatf("coarse %0d rising_edge got %0d want %0d",
                         want.coarse_index, got.rising_edge, want.rising_edge));
      if (got.falling_edge !== want.falling_edge)
        report($sformatf("coarse %0d falling_edge got %0d want %0d",
                         want.coarse_index, got.falling_edge, want.falling_edge));
      if (got.coarse_index !== want.coarse_index)
        report($sformatf("coarse_index got %0d want %0d",
                         got.coarse_index, want.coarse_index));
    endtask

    task report_leftovers();
      tdc_enc_pkg::tdc_out_t want;
      while (awaited_codes.size() != 0) begin
        want = awaited_codes.pop_front();
        report($sformatf("word for coarse %0d never arrived", want.coarse_index));
      end
    endtask
  endclass

endpackage

// ===== tb/tb_tdc_edge_time_encoder.sv =====
`timescale 1ns / 100ps
// Top-level testbench for the TDC edge-time encoder: stimulus, handshakes and watchdog.
module tb_tdc_edge_time_encoder;

  localparam int unsigned STALL_LIMIT       = 1000;
  localparam int unsigned SETTLE_CYCLES     = 4;
  localparam int unsigned DRAIN_CYCLES      = 8;
  localparam int unsigned PHASES            = 6;
  localparam int unsigned PHASE_MIN_SAMPLES = 230;
  localparam int unsigned PHASE_MIN_RESULTS = 4;
  localparam int          AMP_MAX           = 32767;
  localparam int          AMP_MIN           = -32768;
  localparam int unsigned AMP_W             = tdc_enc_pkg::AMP_W;
  localparam int unsigned CODE_W            = tdc_enc_pkg::CODE_W;
  localparam int unsigned IDX_W             = tdc_enc_pkg::CFG_IDX_W;
  localparam int unsigned PAD_W             = AMP_W - CODE_W;
  localparam logic [IDX_W-1:0] CFG_SPARE    = 2'd3;

  typedef enum logic [1:0] {LVL_ABOVE, LVL_BELOW, LVL_AT, LVL_NOISE} level_e;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  tdc_enc_pkg::tdc_in_t  in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  tdc_enc_pkg::tdc_out_t out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [IDX_W-1:0]      cfg_index = '0;
  logic [AMP_W-1:0]      cfg_data  = '0;

  logic                  in_fire  = 1'b0;
  logic                  out_fire = 1'b0;
  logic                  cfg_fire = 1'b0;
  tdc_enc_pkg::tdc_out_t out_word;
  int unsigned snd_idle_pct = 0;
  int unsigned rcv_idle_pct = 0;
  int unsigned n_writes     = 0;
  int unsigned stall_cycles = 0;

  int unsigned frame_left  = 0;
  int unsigned seg_left    = 0;
  level_e      seg_level   = LVL_BELOW;
  bit          first_frame = 1'b1;

  tdc_edge_tb_pkg::tdc_code_checker codes = new();

  always #10 clk_i = ~clk_i;

  tdc_edge_time_encoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // handshakes sampled mid-cycle, consumed at the next rising edge
  always @(negedge clk_i) begin
    in_fire  = rst_ni && in_valid && in_ready;
    out_fire = rst_ni && out_valid && out_ready;
    cfg_fire = rst_ni && cfg_valid && cfg_ready;
    out_word = out_data;
  end

  always @(posedge clk_i) out_ready <= ($urandom_range(99) >= rcv_idle_pct);

  always @(posedge clk_i) begin
    if (out_fire) codes.check_result(out_word);
    if (!rst_ni || in_fire || out_fire || cfg_fire) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("** tdc_edge_time_encoder: FAILED **");
      $finish;
    end
  end

  function automatic logic signed [AMP_W-1:0] level_amp(level_e lvl,
                                                        logic signed [AMP_W-1:0] thr);
    int          t;
    int unsigned span;
    t = int'(thr);
    case (lvl)
      LVL_ABOVE: begin
        if (t == AMP_MAX) return thr;
        span = AMP_MAX - t;
        if ($urandom_range(1) && span > 300) span = 300;
        return AMP_W'(t + 1 + int'($urandom_range(span - 1)));
      end
      LVL_BELOW: begin
        if (t == AMP_MIN) return thr;
        span = t - AMP_MIN;
        if ($urandom_range(1) && span > 300) span = 300;
        return AMP_W'(t - 1 - int'($urandom_range(span - 1)));
      end
      LVL_AT:  return thr;
      default: return AMP_W'($urandom);
    endcase
  endfunction

  // pulse-shaped frames: runs above and below the threshold, rare noise and restarts
  task automatic next_sample(output tdc_enc_pkg::tdc_in_t s);
    int unsigned pick;
    s.frame_start = 1'b0;
    if (frame_left == 0) begin
      s.frame_start = 1'b1;
      if (first_frame) begin
        frame_left = (tdc_enc_pkg::MAX_COARSE + 1) * tdc_enc_pkg::NBINS + 7;
      end else begin
        case ($urandom_range(9))
          0, 1:    frame_left = (tdc_enc_pkg::MAX_COARSE + 1) * tdc_enc_pkg::NBINS
                              + $urandom_range(60);
          2, 3:    frame_left = $urandom_range(1, 120);
          default: frame_left = tdc_enc_pkg::NBINS * $urandom_range(1, 6);
        endcase
      end
      first_frame = 1'b0;
    end else if (frame_left < 4 * tdc_enc_pkg::NBINS && $urandom_range(299) == 0) begin
      s.frame_start = 1'b1;
    end
    frame_left--;
    if (seg_left == 0) begin
      pick = $urandom_range(99);
      if (pick < 42)      seg_level = LVL_ABOVE;
      else if (pick < 84) seg_level = LVL_BELOW;
      else if (pick < 92) seg_level = LVL_AT;
      else                seg_level = LVL_NOISE;
      seg_left = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 70);
    end
    seg_left--;
    if ($urandom_range(29) == 0) s.amplitude = level_amp(LVL_NOISE, codes.regs.threshold);
    else s.amplitude = level_amp(seg_level, codes.regs.threshold);
  endtask

  task automatic send_sample(input tdc_enc_pkg::tdc_in_t s);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk_i); while (!in_fire);
    codes.note_sample(s);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [AMP_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_fire);
    codes.apply_register(idx, data);
    n_writes++;
  endtask

  task automatic run_directed();
    logic [AMP_W:0] plan [18];
    plan = '{
      {16'h0000, 1'b1},  // at threshold on frame start
      {16'h7fff, 1'b0},  // rise
      {16'h8000, 1'b0},  // below, off the fall phase
      {16'hffff, 1'b0},  // fall
      {16'h0001, 1'b0},  // second rise
      {16'h0000, 1'b0},
      {16'h0000, 1'b0},  // at threshold on fall phase
      {16'hfffb, 1'b0},
      {16'hfffb, 1'b0},
      {16'h8000, 1'b0},  // fall
      {16'h0064, 1'b1},  // restart mid coarse sample
      {16'h5555, 1'b0},
      {16'haaaa, 1'b0},
      {16'haaaa, 1'b0},  // fall
      {16'h5555, 1'b1},
      {16'h7fff, 1'b0},
      {16'h0000, 1'b0},
      {16'h0000, 1'b0}
    };
    foreach (plan[i]) send_sample(tdc_enc_pkg::tdc_in_t'(plan[i]));
  endtask

  task automatic program_setting(input int unsigned setting);
    logic [AMP_W-1:0]  thr;
    logic [CODE_W-1:0] no_code;
    logic [CODE_W-1:0] already_code;
    logic [PAD_W-1:0]  pad_a;
    logic [PAD_W-1:0]  pad_b;
    pad_a = PAD_W'($urandom);
    pad_b = PAD_W'($urandom);
    case (setting)
      1: begin
        thr = 16'h8000; no_code = '1; already_code = '0;
      end
      2: begin
        thr = 16'h7fff; no_code = '0; already_code = '1;
      end
      3: begin
        thr = AMP_W'($urandom_range(4000)) - 16'd2000;
        no_code = CODE_W'($urandom); already_code = CODE_W'($urandom);
      end
      4: begin
        thr = 16'hffff; no_code = 7'd1; already_code = 7'd126;
      end
      default: begin
        thr = AMP_W'($urandom);
        no_code = CODE_W'($urandom); already_code = CODE_W'($urandom);
      end
    endcase
    while (codes.awaited_codes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(tdc_enc_pkg::CFG_THRESHOLD, thr);
    write_reg(CFG_SPARE, AMP_W'($urandom));
    write_reg(tdc_enc_pkg::CFG_NO_TRANS, {pad_a, no_code});
    write_reg(tdc_enc_pkg::CFG_ALREADY, {pad_b, already_code});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    tdc_enc_pkg::tdc_in_t s;
    int unsigned          first_sample;
    int unsigned          first_result;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int unsigned p = 0; p < PHASES; p++) begin
      case (p / 2)
        0: begin
          snd_idle_pct = 24; rcv_idle_pct = 52;
        end
        1: begin
          snd_idle_pct = 52; rcv_idle_pct = 24;
        end
        default: begin
          snd_idle_pct = 0; rcv_idle_pct = 0;
        end
      endcase
      if (p == 0) run_directed();
      else program_setting(p);
      first_sample = codes.n_samples;
      first_result = codes.n_predicted;
      while (codes.n_samples - first_sample < PHASE_MIN_SAMPLES ||
             codes.n_predicted - first_result < PHASE_MIN_RESULTS) begin
        next_sample(s);
        send_sample(s);
      end
      in_valid <= 1'b0;
    end
    while (codes.awaited_codes.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    codes.report_leftovers();
    $display("Run drove %0d samples and checked %0d coarse-sample words over %0d settings",
             codes.n_samples, codes.n_checked, PHASES);
    $display("(%0d register writes), with frame restarts, coarse wrap and three idle mixes.",
             n_writes);
    if (codes.n_errors == 0) begin
      $display("** tdc_edge_time_encoder: PASSED **");
    end else begin
      $display("** tdc_edge_time_encoder: FAILED **");
    end
    $finish;
  end

endmodule
